### hdl/sfcs_pkg.sv
// ----------------------------------------------------------------------------
// sfcs_pkg
// Shared types and constants of the serial flash command sequencer.
// ----------------------------------------------------------------------------
package sfcs_pkg;

    localparam int ADDR_BITS   = 24;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [23:0] ADDR_MASK =
        (ADDR_BITS >= 24) ? 24'hFF_FFFF : 24'((32'd1 << ADDR_BITS) - 32'd1);

    // request codes
    localparam logic [3:0] CMD_WREN       = 4'd0;
    localparam logic [3:0] CMD_WRDI       = 4'd1;
    localparam logic [3:0] CMD_RDSR1      = 4'd2;
    localparam logic [3:0] CMD_RDSR2      = 4'd3;
    localparam logic [3:0] CMD_WRSR       = 4'd4;
    localparam logic [3:0] CMD_ERASE      = 4'd5;
    localparam logic [3:0] CMD_PROG_START = 4'd6;
    localparam logic [3:0] CMD_PROG_DATA  = 4'd7;
    localparam logic [3:0] CMD_READ_START = 4'd8;
    localparam logic [3:0] CMD_READ_DATA  = 4'd9;
    localparam logic [3:0] CMD_READ_ID    = 4'd10;
    localparam logic [3:0] CMD_STATUS_RSP = 4'd11;

    // result kinds
    localparam logic [1:0] KIND_FRAME = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // flash opcodes
    localparam logic [7:0] OP_WREN  = 8'h06;
    localparam logic [7:0] OP_WRDI  = 8'h04;
    localparam logic [7:0] OP_RDSR1 = 8'h05;
    localparam logic [7:0] OP_RDSR2 = 8'h35;
    localparam logic [7:0] OP_WRSR  = 8'h01;
    localparam logic [7:0] OP_SE4K  = 8'h20;
    localparam logic [7:0] OP_PP    = 8'h02;
    localparam logic [7:0] OP_READ  = 8'h03;
    localparam logic [7:0] OP_RDID  = 8'h90;

    // configuration register indexes
    localparam logic [1:0] CFG_BUSY_MASK = 2'd0;
    localparam logic [1:0] CFG_DUMMY_TX  = 2'd1;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_PROG = 2'd1,
        PH_READ = 2'd2,
        PH_POLL = 2'd3
    } phase_t;

    typedef enum logic [3:0] {
        JOB_WREN,
        JOB_WRDI,
        JOB_RDSR1,
        JOB_RDSR2,
        JOB_WRSR,
        JOB_ERASE,
        JOB_PROG_START,
        JOB_PROG_DATA,
        JOB_READ_START,
        JOB_READ_DATA,
        JOB_READ_ID,
        JOB_POLL,
        JOB_DONE,
        JOB_ERROR
    } job_op_t;

    typedef struct packed {
        logic [3:0]  command;
        logic [23:0] address;
        logic [7:0]  data_byte;
        logic [7:0]  second_byte;
        logic        last;
    } req_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] tx_byte;
        logic       sample_rx;
        logic       release_select;
        logic       run_end;
    } res_t;

    typedef struct packed {
        job_op_t     op;
        logic [23:0] addr;
        logic [7:0]  d1;
        logic [7:0]  d2;
        logic        last;
    } job_t;

endpackage

### hdl/sfcs_front.sv
// ----------------------------------------------------------------------------
// sfcs_front
// Accepts requests, tracks the run phase and turns each request into a job.
// ----------------------------------------------------------------------------
module sfcs_front
    import sfcs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  req_t       req_beat,
    input  logic [7:0] busy_mask,
    input  logic       queue_full,
    output logic       push,
    output job_t       push_job
);

    phase_t phase_reg;
    phase_t phase_next;
    job_op_t op;

    assign req_stall = queue_full;
    assign push      = req_valid && !queue_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
        end
        else if (push)
        begin
            phase_reg <= phase_next;
        end
    end

    always_comb
    begin
        op         = JOB_ERROR;
        phase_next = phase_reg;
        case (phase_reg)
            PH_IDLE:
            begin
                case (req_beat.command)
                    CMD_WREN:  op = JOB_WREN;
                    CMD_WRDI:  op = JOB_WRDI;
                    CMD_RDSR1: op = JOB_RDSR1;
                    CMD_RDSR2: op = JOB_RDSR2;
                    CMD_WRSR:
                    begin
                        op         = JOB_WRSR;
                        phase_next = PH_POLL;
                    end
                    CMD_ERASE:
                    begin
                        op         = JOB_ERASE;
                        phase_next = PH_POLL;
                    end
                    CMD_PROG_START:
                    begin
                        op         = JOB_PROG_START;
                        phase_next = PH_PROG;
                    end
                    CMD_READ_START:
                    begin
                        op         = JOB_READ_START;
                        phase_next = PH_READ;
                    end
                    CMD_READ_ID: op = JOB_READ_ID;
                    default:     op = JOB_ERROR;
                endcase
            end
            PH_PROG:
            begin
                if (req_beat.command == CMD_PROG_DATA)
                begin
                    op = JOB_PROG_DATA;
                    if (req_beat.last)
                    begin
                        phase_next = PH_POLL;
                    end
                end
            end
            PH_READ:
            begin
                if (req_beat.command == CMD_READ_DATA)
                begin
                    op = JOB_READ_DATA;
                    if (req_beat.last)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
            end
            default:
            begin
                if (req_beat.command == CMD_STATUS_RSP)
                begin
                    if ((req_beat.data_byte & busy_mask) != 8'd0)
                    begin
                        op = JOB_POLL;
                    end
                    else
                    begin
                        op         = JOB_DONE;
                        phase_next = PH_IDLE;
                    end
                end
            end
        endcase
    end

    always_comb
    begin
        push_job.op   = op;
        push_job.addr = req_beat.address & ADDR_MASK;
        push_job.d1   = req_beat.data_byte;
        push_job.d2   = req_beat.second_byte;
        push_job.last = req_beat.last;
    end

endmodule

### hdl/sfcs_queue.sv
// ----------------------------------------------------------------------------
// sfcs_queue
// Short job queue between the request front end and the frame sequencer.
// ----------------------------------------------------------------------------
module sfcs_queue
    import sfcs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output logic full,
    output logic not_empty,
    output job_t head
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

### hdl/sfcs_back.sv
// ----------------------------------------------------------------------------
// sfcs_back
// Steps through the frames of each queued job, one result per cycle unless
// res_stall holds a valid beat, into the output register.
// ----------------------------------------------------------------------------
module sfcs_back
    import sfcs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       job_valid,
    input  job_t       job,
    input  logic [7:0] dummy_tx,
    output logic       pop,
    output logic       res_valid,
    input  logic       res_stall,
    output res_t       res_beat
);

    logic [2:0] step_reg;
    logic       valid_reg;
    res_t       beat_reg;
    logic       load;
    logic [2:0] len;
    logic       final_step;
    res_t       beat_next;

    function automatic logic [2:0] job_len(job_t j);
        logic [2:0] n;
        case (j.op)
            JOB_RDSR1, JOB_RDSR2, JOB_POLL: n = 3'd2;
            JOB_WRSR, JOB_READ_ID:          n = 3'd6;
            JOB_ERASE:                      n = 3'd7;
            JOB_PROG_START:                 n = 3'd5;
            JOB_READ_START:                 n = 3'd4;
            JOB_PROG_DATA:                  n = j.last ? 3'd3 : 3'd1;
            default:                        n = 3'd1;
        endcase
        return n;
    endfunction

    // tx byte, sample, release for one step of a job
    function automatic res_t frame_at(job_t j, logic [2:0] s, logic [7:0] dm);
        res_t f;
        f = '0;
        f.kind = KIND_FRAME;
        case (j.op)
            JOB_WREN:
            begin
                f.tx_byte = OP_WREN;
                f.release_select = 1'b1;
            end
            JOB_WRDI:
            begin
                f.tx_byte = OP_WRDI;
                f.release_select = 1'b1;
            end
            JOB_RDSR1, JOB_RDSR2, JOB_POLL:
            begin
                if (s == 3'd0)
                begin
                    f.tx_byte = (j.op == JOB_RDSR2) ? OP_RDSR2 : OP_RDSR1;
                end
                else
                begin
                    f.tx_byte = dm;
                    f.sample_rx = 1'b1;
                    f.release_select = 1'b1;
                end
            end
            JOB_WRSR:
            begin
                case (s)
                    3'd0:
                    begin
                        f.tx_byte = OP_WREN;
                        f.release_select = 1'b1;
                    end
                    3'd1: f.tx_byte = OP_WRSR;
                    3'd2: f.tx_byte = j.d1;
                    3'd3:
                    begin
                        f.tx_byte = j.d2;
                        f.release_select = 1'b1;
                    end
                    3'd4: f.tx_byte = OP_RDSR1;
                    default:
                    begin
                        f.tx_byte = dm;
                        f.sample_rx = 1'b1;
                        f.release_select = 1'b1;
                    end
                endcase
            end
            JOB_ERASE, JOB_PROG_START:
            begin
                case (s)
                    3'd0:
                    begin
                        f.tx_byte = OP_WREN;
                        f.release_select = 1'b1;
                    end
                    3'd1: f.tx_byte = (j.op == JOB_ERASE) ? OP_SE4K : OP_PP;
                    3'd2: f.tx_byte = j.addr[23:16];
                    3'd3: f.tx_byte = j.addr[15:8];
                    3'd4:
                    begin
                        f.tx_byte = j.addr[7:0];
                        f.release_select = (j.op == JOB_ERASE);
                    end
                    3'd5: f.tx_byte = OP_RDSR1;
                    default:
                    begin
                        f.tx_byte = dm;
                        f.sample_rx = 1'b1;
                        f.release_select = 1'b1;
                    end
                endcase
            end
            JOB_PROG_DATA:
            begin
                case (s)
                    3'd0:
                    begin
                        f.tx_byte = j.d1;
                        f.release_select = j.last;
                    end
                    3'd1: f.tx_byte = OP_RDSR1;
                    default:
                    begin
                        f.tx_byte = dm;
                        f.sample_rx = 1'b1;
                        f.release_select = 1'b1;
                    end
                endcase
            end
            JOB_READ_START:
            begin
                case (s)
                    3'd0:    f.tx_byte = OP_READ;
                    3'd1:    f.tx_byte = j.addr[23:16];
                    3'd2:    f.tx_byte = j.addr[15:8];
                    default: f.tx_byte = j.addr[7:0];
                endcase
            end
            JOB_READ_DATA:
            begin
                f.tx_byte = dm;
                f.sample_rx = 1'b1;
                f.release_select = j.last;
            end
            JOB_READ_ID:
            begin
                case (s)
                    3'd0: f.tx_byte = OP_RDID;
                    3'd1, 3'd2, 3'd3: f.tx_byte = 8'h00;
                    3'd4:
                    begin
                        f.tx_byte = dm;
                        f.sample_rx = 1'b1;
                    end
                    default:
                    begin
                        f.tx_byte = dm;
                        f.sample_rx = 1'b1;
                        f.release_select = 1'b1;
                    end
                endcase
            end
            JOB_DONE:  f.kind = KIND_DONE;
            default:   f.kind = KIND_ERROR;
        endcase
        return f;
    endfunction

    assign load       = job_valid && (!valid_reg || !res_stall);
    assign len        = job_len(job);
    assign final_step = (step_reg == len - 3'd1);
    assign pop        = load && final_step;
    assign res_valid  = valid_reg;
    assign res_beat   = beat_reg;

    always_comb
    begin
        beat_next         = frame_at(job, step_reg, dummy_tx);
        beat_next.run_end = final_step;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                step_reg  <= final_step ? 3'd0 : step_reg + 3'd1;
                valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            beat_reg <= beat_next;
        end
    end

endmodule

### hdl/serial_flash_command_sequencer.sv
// ----------------------------------------------------------------------------
// serial_flash_command_sequencer
// Turns host flash requests into SPI byte frames for a serial NOR flash.
//
// Requests enter on req_valid / req_stall / req_beat; a beat is taken on a
// rising edge with req_valid high and req_stall low. Results leave on
// res_valid / res_stall / res_beat under the same rule. Configuration
// writes use cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high, index 0 is the busy mask, index 1 the dummy tx byte.
// The front end takes one request per cycle unless the job queue is full,
// classifying it against the run phase; a four-entry job queue feeds the
// back end, which emits one result per cycle from its output register
// unless res_stall holds it. A request gives 1 to 7 results, passing the
// job queue and then the output register. req_stall rises only when the
// job queue is full. If res_stall is high the output register holds a
// valid beat and the back end waits; the queue then fills and backs up
// into req_stall. Reset clears the phase to idle, empties the queue and
// output register and sets the busy mask to 1 and the dummy byte to 0.
// ----------------------------------------------------------------------------
module serial_flash_command_sequencer
    import sfcs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  req_t       req_beat,
    output logic       res_valid,
    input  logic       res_stall,
    output res_t       res_beat,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    logic [7:0] busy_mask_reg;
    logic [7:0] dummy_tx_reg;
    logic       push;
    job_t       push_job;
    logic       pop;
    logic       queue_full;
    logic       job_valid;
    job_t       head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_mask_reg <= 8'd1;
            dummy_tx_reg  <= 8'd0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_BUSY_MASK)
            begin
                busy_mask_reg <= cfg_data;
            end
            else if (cfg_index == CFG_DUMMY_TX)
            begin
                dummy_tx_reg <= cfg_data;
            end
        end
    end

    sfcs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_beat   (req_beat),
        .busy_mask  (busy_mask_reg),
        .queue_full (queue_full),
        .push       (push),
        .push_job   (push_job)
    );

    sfcs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .pop       (pop),
        .full      (queue_full),
        .not_empty (job_valid),
        .head      (head)
    );

    sfcs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (head),
        .dummy_tx  (dummy_tx_reg),
        .pop       (pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_beat  (res_beat)
    );

endmodule

### dv/serial_flash_command_sequencer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_flash_command_sequencer_checker
// Watches the request, result and configuration channels of the flash command
// sequencer. It keeps its own copy of the run phase and the two registers,
// turns every accepted request into the SPI frames it should produce, and
// compares each accepted result beat with the oldest frame still owed.
// ----------------------------------------------------------------------------
module serial_flash_command_sequencer_checker
    import sfcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_stall,
    input  req_t        req_beat,
    input  logic        res_valid,
    input  logic        res_stall,
    input  res_t        res_beat,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    output int unsigned fail_count,
    output int unsigned results_due
);

    phase_t      seq_phase     = PH_IDLE;
    logic [7:0]  busy_mask     = 8'h01;
    logic [7:0]  dummy_byte    = 8'h00;
    res_t        frames_owed[$];
    res_t        new_frames[$];
    res_t        want;
    int unsigned wrong_results = 0;

    assign fail_count = wrong_results;

    function automatic void add_frame(input logic [1:0] k, input logic [7:0] tx,
                                      input logic smp, input logic rel);
        res_t f;
        f.kind           = k;
        f.tx_byte        = tx;
        f.sample_rx      = smp;
        f.release_select = rel;
        f.run_end        = 1'b0;
        new_frames.push_back(f);
    endfunction

    function automatic void add_status_poll();
        add_frame(KIND_FRAME, OP_RDSR1, 1'b0, 1'b0);
        add_frame(KIND_FRAME, dummy_byte, 1'b1, 1'b1);
    endfunction

    function automatic void add_address(input logic [23:0] a, input logic rel);
        add_frame(KIND_FRAME, a[23:16], 1'b0, 1'b0);
        add_frame(KIND_FRAME, a[15:8], 1'b0, 1'b0);
        add_frame(KIND_FRAME, a[7:0], 1'b0, rel);
    endfunction

    function automatic void frames_for_request(input req_t r);
        logic [23:0] a;
        logic        bad;
        a   = r.address & ADDR_MASK;
        bad = 1'b0;
        new_frames.delete();
        case (seq_phase)
            PH_IDLE:
            begin
                case (r.command)
                    CMD_WREN:  add_frame(KIND_FRAME, OP_WREN, 1'b0, 1'b1);
                    CMD_WRDI:  add_frame(KIND_FRAME, OP_WRDI, 1'b0, 1'b1);
                    CMD_RDSR1: add_status_poll();
                    CMD_RDSR2:
                    begin
                        add_frame(KIND_FRAME, OP_RDSR2, 1'b0, 1'b0);
                        add_frame(KIND_FRAME, dummy_byte, 1'b1, 1'b1);
                    end
                    CMD_WRSR:
                    begin
                        add_frame(KIND_FRAME, OP_WREN, 1'b0, 1'b1);
                        add_frame(KIND_FRAME, OP_WRSR, 1'b0, 1'b0);
                        add_frame(KIND_FRAME, r.data_byte, 1'b0, 1'b0);
                        add_frame(KIND_FRAME, r.second_byte, 1'b0, 1'b1);
                        add_status_poll();
                        seq_phase = PH_POLL;
                    end
                    CMD_ERASE:
                    begin
                        add_frame(KIND_FRAME, OP_WREN, 1'b0, 1'b1);
                        add_frame(KIND_FRAME, OP_SE4K, 1'b0, 1'b0);
                        add_address(a, 1'b1);
                        add_status_poll();
                        seq_phase = PH_POLL;
                    end
                    CMD_PROG_START:
                    begin
                        add_frame(KIND_FRAME, OP_WREN, 1'b0, 1'b1);
                        add_frame(KIND_FRAME, OP_PP, 1'b0, 1'b0);
                        add_address(a, 1'b0);
                        seq_phase = PH_PROG;
                    end
                    CMD_READ_START:
                    begin
                        add_frame(KIND_FRAME, OP_READ, 1'b0, 1'b0);
                        add_address(a, 1'b0);
                        seq_phase = PH_READ;
                    end
                    CMD_READ_ID:
                    begin
                        add_frame(KIND_FRAME, OP_RDID, 1'b0, 1'b0);
                        add_address(24'h000000, 1'b0);
                        add_frame(KIND_FRAME, dummy_byte, 1'b1, 1'b0);
                        add_frame(KIND_FRAME, dummy_byte, 1'b1, 1'b1);
                    end
                    default:   bad = 1'b1;
                endcase
            end
            PH_PROG:
            begin
                if (r.command == CMD_PROG_DATA)
                begin
                    add_frame(KIND_FRAME, r.data_byte, 1'b0, r.last);
                    if (r.last)
                    begin
                        add_status_poll();
                        seq_phase = PH_POLL;
                    end
                end
                else
                    bad = 1'b1;
            end
            PH_READ:
            begin
                if (r.command == CMD_READ_DATA)
                begin
                    add_frame(KIND_FRAME, dummy_byte, 1'b1, r.last);
                    if (r.last)
                        seq_phase = PH_IDLE;
                end
                else
                    bad = 1'b1;
            end
            default:
            begin
                if (r.command == CMD_STATUS_RSP)
                begin
                    if ((r.data_byte & busy_mask) != 8'h00)
                        add_status_poll();
                    else
                    begin
                        add_frame(KIND_DONE, 8'h00, 1'b0, 1'b0);
                        seq_phase = PH_IDLE;
                    end
                end
                else
                    bad = 1'b1;
            end
        endcase
        if (bad)
            add_frame(KIND_ERROR, 8'h00, 1'b0, 1'b0);
        new_frames[new_frames.size() - 1].run_end = 1'b1;
        foreach (new_frames[i])
            frames_owed.push_back(new_frames[i]);
    endfunction

    task automatic check_field(input string name, input logic [7:0] exp_val,
                               input logic [7:0] act_val);
        if (exp_val !== act_val)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, exp_val, act_val);
            wrong_results++;
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            seq_phase  = PH_IDLE;
            busy_mask  = 8'h01;
            dummy_byte = 8'h00;
            frames_owed.delete();
            results_due <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_BUSY_MASK)
                    busy_mask = cfg_data;
                else if (cfg_index == CFG_DUMMY_TX)
                    dummy_byte = cfg_data;
            end
            if (res_valid && !res_stall)
            begin
                if (frames_owed.size() == 0)
                begin
                    $display("%0t: result beat %p with none expected", $time, res_beat);
                    wrong_results++;
                end
                else
                begin
                    want = frames_owed.pop_front();
                    check_field("kind", 8'(want.kind), 8'(res_beat.kind));
                    check_field("tx_byte", want.tx_byte, res_beat.tx_byte);
                    check_field("sample_rx", 8'(want.sample_rx), 8'(res_beat.sample_rx));
                    check_field("release_select", 8'(want.release_select),
                                8'(res_beat.release_select));
                    check_field("run_end", 8'(want.run_end), 8'(res_beat.run_end));
                end
            end
            if (req_valid && !req_stall)
                frames_for_request(req_beat);
            results_due <= frames_owed.size();
        end
    end

endmodule

### dv/serial_flash_command_sequencer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_flash_command_sequencer_tb
// Drives host requests into the flash command sequencer: a directed pass over
// every request, the out-of-sequence cases and busy polling, then random
// well-formed runs mixed with noise under several register settings, with
// random gaps and stalls on both channels. The checker beside the block
// predicts and compares every result beat.
// ----------------------------------------------------------------------------
module serial_flash_command_sequencer_tb;
    import sfcs_pkg::*;

    localparam int         STALL_LIMIT   = 2000;
    localparam int         HOLD_CYCLES   = 200;
    localparam int         RANDOM_ITEMS  = 60;
    localparam logic [3:0] CMD_UNUSED_LO = 4'd12;
    localparam logic [3:0] CMD_UNUSED_HI = 4'd15;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    req_t        req_beat  = '0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    res_t        res_beat;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_BUSY_MASK;
    logic [7:0]  cfg_data  = 8'h00;

    int unsigned fail_count;
    int unsigned results_due;
    int unsigned items_sent   = 0;
    int unsigned idle_cycles  = 0;
    logic [7:0]  cur_mask     = 8'h01;
    bit          quiet        = 1'b0;
    bit          hold_results = 1'b0;

    logic [3:0]  simple_cmds [5] = '{CMD_WREN, CMD_WRDI, CMD_RDSR1, CMD_RDSR2, CMD_READ_ID};
    logic [3:0]  idle_noise [8]  = '{CMD_WREN, CMD_WRDI, CMD_RDSR1, CMD_RDSR2,
                                     CMD_PROG_DATA, CMD_READ_DATA, CMD_READ_ID,
                                     CMD_STATUS_RSP};

    serial_flash_command_sequencer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_beat  (req_beat),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_beat  (res_beat),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    serial_flash_command_sequencer_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req_beat    (req_beat),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .res_beat    (res_beat),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .results_due (results_due)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int unsigned gap_len();
        int unsigned r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic req_t beat_of(input logic [3:0] cmd, input logic [23:0] addr,
                                     input logic [7:0] d1, input logic [7:0] d2,
                                     input logic last);
        req_t b;
        b.command     = cmd;
        b.address     = addr;
        b.data_byte   = d1;
        b.second_byte = d2;
        b.last        = last;
        return b;
    endfunction

    function automatic req_t rand_beat(input logic [3:0] cmd, input logic last);
        return beat_of(cmd, 24'($urandom), 8'($urandom), 8'($urandom), last);
    endfunction

    function automatic req_t wrong_beat(input logic [3:0] allowed);
        logic [3:0] c;
        do
            c = 4'($urandom);
        while (c == allowed);
        return rand_beat(c, 1'($urandom));
    endfunction

    task automatic send(input req_t beat);
        int unsigned gap;
        req_beat  <= beat;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        items_sent++;
        gap = gap_len();
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // drop valid, then wait until every owed result beat has been taken
    task automatic wait_idle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0)
            @(posedge clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [7:0] val);
        wait_idle();
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_BUSY_MASK)
            cur_mask = val;
    endtask

    task automatic send_status(input logic [7:0] status);
        send(beat_of(CMD_STATUS_RSP, 24'($urandom), status, 8'($urandom), 1'($urandom)));
    endtask

    // a few busy answers, an occasional stray request, then a ready answer
    task automatic answer_polls();
        int unsigned busy_answers;
        logic [7:0]  status;
        busy_answers = (cur_mask == 8'h00) ? 0 : $urandom_range(0, 3);
        repeat (busy_answers)
        begin
            if ($urandom_range(0, 9) == 0)
                send(wrong_beat(CMD_STATUS_RSP));
            status = 8'($urandom);
            if ((status & cur_mask) == 8'h00)
                status = status | cur_mask;
            send_status(status);
        end
        send_status(8'($urandom) & ~cur_mask);
    endtask

    task automatic random_sequence();
        int unsigned pick;
        int unsigned n;
        pick = $urandom_range(0, 99);
        if (pick < 20)
            send(rand_beat(simple_cmds[$urandom_range(0, 4)], 1'($urandom)));
        else if (pick < 35)
        begin
            send(rand_beat(($urandom_range(0, 1) != 0) ? CMD_WRSR : CMD_ERASE,
                           1'($urandom)));
            answer_polls();
        end
        else if (pick < 55)
        begin
            send(rand_beat(CMD_PROG_START, 1'($urandom)));
            n = $urandom_range(1, 5);
            repeat (n - 1)
            begin
                if ($urandom_range(0, 7) == 0)
                    send(wrong_beat(CMD_PROG_DATA));
                send(rand_beat(CMD_PROG_DATA, 1'b0));
            end
            send(rand_beat(CMD_PROG_DATA, 1'b1));
            answer_polls();
        end
        else if (pick < 75)
        begin
            send(rand_beat(CMD_READ_START, 1'($urandom)));
            n = $urandom_range(1, 5);
            repeat (n - 1)
            begin
                if ($urandom_range(0, 7) == 0)
                    send(wrong_beat(CMD_READ_DATA));
                send(rand_beat(CMD_READ_DATA, 1'b0));
            end
            send(rand_beat(CMD_READ_DATA, 1'b1));
        end
        else if (pick < 90)
            send(rand_beat(idle_noise[$urandom_range(0, 7)], 1'($urandom)));
        else
            send(rand_beat(4'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)),
                           1'($urandom)));
    endtask

    // result side: random stalls, or one long hold-off on request
    initial
    begin
        int unsigned n;
        forever
        begin
            @(posedge clk);
            if (hold_results)
            begin
                res_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                res_stall <= 1'b0;
                hold_results = 1'b0;
            end
            else
            begin
                n = gap_len();
                if (n == 0)
                    res_stall <= 1'b0;
                else
                begin
                    res_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                    res_stall <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (res_valid && !res_stall)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
            $display("TEST FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int unsigned phase_start;
        logic [7:0]  mask_val;
        logic [7:0]  dummy_val;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset register values
        send(beat_of(CMD_WREN, 24'h000000, 8'h00, 8'h00, 1'b0));
        send(beat_of(CMD_WRDI, 24'hFFFFFF, 8'hFF, 8'hFF, 1'b1));
        send(beat_of(CMD_RDSR1, 24'h000000, 8'h00, 8'h00, 1'b0));
        send(beat_of(CMD_RDSR2, 24'h000000, 8'h00, 8'h00, 1'b0));
        send(beat_of(CMD_READ_ID, 24'hFFFFFF, 8'hFF, 8'hFF, 1'b1));
        send(beat_of(CMD_WRSR, 24'h000000, 8'hFF, 8'h00, 1'b0));
        send(beat_of(CMD_STATUS_RSP, 24'h000000, 8'h01, 8'h00, 1'b0));
        send(beat_of(CMD_STATUS_RSP, 24'h000000, 8'h00, 8'h00, 1'b0));
        send(beat_of(CMD_ERASE, 24'hFFFFFF, 8'h00, 8'h00, 1'b0));
        send(beat_of(CMD_STATUS_RSP, 24'h000000, 8'hFE, 8'h00, 1'b0));
        send(beat_of(CMD_PROG_START, 24'h000000, 8'h00, 8'h00, 1'b0));
        send(beat_of(CMD_PROG_DATA, 24'h000000, 8'hFF, 8'h00, 1'b0));
        send(beat_of(CMD_WREN, 24'h000000, 8'h00, 8'h00, 1'b0));
        send(beat_of(CMD_PROG_DATA, 24'h000000, 8'h00, 8'h00, 1'b1));
        send(beat_of(CMD_WREN, 24'h000000, 8'h00, 8'h00, 1'b0));
        send(beat_of(CMD_STATUS_RSP, 24'h000000, 8'h00, 8'h00, 1'b0));
        send(beat_of(CMD_READ_START, 24'hA5A5A5, 8'h00, 8'h00, 1'b0));
        send(beat_of(CMD_RDSR1, 24'h000000, 8'h00, 8'h00, 1'b0));
        send(beat_of(CMD_READ_DATA, 24'h000000, 8'h00, 8'h00, 1'b0));
        send(beat_of(CMD_READ_DATA, 24'h000000, 8'h00, 8'h00, 1'b1));
        send(beat_of(CMD_PROG_DATA, 24'h000000, 8'h00, 8'h00, 1'b1));
        send(beat_of(CMD_READ_DATA, 24'h000000, 8'h00, 8'h00, 1'b1));
        send(beat_of(CMD_STATUS_RSP, 24'h000000, 8'h00, 8'h00, 1'b0));
        send(beat_of(CMD_UNUSED_LO, 24'h000000, 8'h00, 8'h00, 1'b0));
        send(beat_of(CMD_UNUSED_HI, 24'hFFFFFF, 8'hFF, 8'hFF, 1'b1));

        // zero mask completes on the first answer
        write_cfg(CFG_BUSY_MASK, 8'h00);
        write_cfg(CFG_DUMMY_TX, 8'hFF);
        send(beat_of(CMD_WRSR, 24'h000000, 8'h00, 8'hFF, 1'b0));
        send(beat_of(CMD_STATUS_RSP, 24'h000000, 8'hFF, 8'h00, 1'b0));

        for (int i = 0; i < 4; i++)
        begin
            case (i)
                0:
                begin
                    mask_val  = 8'hFF;
                    dummy_val = 8'h00;
                end
                1:
                begin
                    mask_val  = 8'h00;
                    dummy_val = 8'hFF;
                end
                2:
                begin
                    mask_val  = 8'($urandom);
                    dummy_val = 8'($urandom);
                end
                default:
                begin
                    mask_val  = 8'h01;
                    dummy_val = 8'hA5;
                end
            endcase
            write_cfg(CFG_BUSY_MASK, mask_val);
            write_cfg(CFG_DUMMY_TX, dummy_val);
            phase_start = items_sent;

            if (i == 1)
            begin
                // back up the job queue into req_stall, then drain fully
                hold_results = 1'b1;
                quiet = 1'b1;
                repeat (12) send(rand_beat(simple_cmds[$urandom_range(0, 4)], 1'($urandom)));
                quiet = 1'b0;
                wait_idle();
            end
            if (i == 2)
                quiet = 1'b1;

            while (items_sent - phase_start < RANDOM_ITEMS / 4)
            begin
                random_sequence();
                if (items_sent - phase_start >= 10)
                    quiet = 1'b0;
            end
            quiet = 1'b0;
        end

        wait_idle();
        repeat (20) @(posedge clk);
        if (results_due != 0)
            $display("%0t: %0d result beats never arrived", $time, results_due);
        if (fail_count == 0 && results_due == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
